// File: design/ogs_pkg.sv
// Shared widths, control struct and defaults for the orientation gradient step
package ogs_pkg;

	localparam int FRAC_BITS_DEF = 14;

	// Field and datapath widths
	localparam int Q_W    = 16;  // quaternion component
	localparam int A_W    = 16;  // accelerometer sample magnitude
	localparam int SQ_W   = 32;  // accelerometer square and norm-squared sum
	localparam int RAD_W  = 62;  // square root radicand
	localparam int ROOT_W = 31;  // square root result, also divisor width
	localparam int F_W    = 35;  // gravity error terms
	localparam int G_W    = 56;  // raw gradient components
	localparam int M_W    = 30;  // normalized gradient magnitudes
	localparam int O_W    = 16;  // result fields

	// Control that travels with each request down the pipeline
	typedef struct packed {
		logic vld;  // stage holds a request
		logic az;   // accelerometer vector is zero
		logic gz;   // gradient is zero
	} ctl_t;

endpackage

// File: design/orientation_gradient_step.sv
// Top level: accelerometer-only orientation filter gradient step, fully pipelined
//
//  channel   signals                                  handshake
//  request   quat_w/x/y/z, accel_x/y/z                start, busy (taken when start & !busy)
//  result    grad_w/x/y/z, accel_zero                 done, one cycle, no back-pressure
//
// One request is taken every cycle; busy stays low. Each result passes through
// the two 31-stage square root pipelines and the two (FRAC_BITS+2)-stage dividers.
// Reset clears only the control bits; no result is shown until a request has passed.
module orientation_gradient_step #(
	parameter int FRAC_BITS = ogs_pkg::FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [ogs_pkg::Q_W-1:0]          quat_w,
	input  logic signed [ogs_pkg::Q_W-1:0]          quat_x,
	input  logic signed [ogs_pkg::Q_W-1:0]          quat_y,
	input  logic signed [ogs_pkg::Q_W-1:0]          quat_z,
	input  logic signed [ogs_pkg::A_W-1:0]          accel_x,
	input  logic signed [ogs_pkg::A_W-1:0]          accel_y,
	input  logic signed [ogs_pkg::A_W-1:0]          accel_z,
	output logic                                    done,
	output logic signed [ogs_pkg::O_W-1:0]          grad_w,
	output logic signed [ogs_pkg::O_W-1:0]          grad_x,
	output logic signed [ogs_pkg::O_W-1:0]          grad_y,
	output logic signed [ogs_pkg::O_W-1:0]          grad_z,
	output logic                                    accel_zero
);
	import ogs_pkg::*;

	localparam int QW  = FRAC_BITS + 2;
	localparam int NW  = QW + ROOT_W;
	localparam int LAT = 2 * ROOT_W + 2 * QW + 15;
	localparam int OW  = (QW > O_W + 1) ? QW : O_W + 1;
	localparam int QV  = 4 * Q_W;
	localparam int SB1 = QV + 3 * A_W + 3;
	localparam int SB2 = QV + 3;
	localparam int SB3 = 4 * M_W + 4;
	localparam logic [OW-1:0] POS_LIM = OW'(32767);
	localparam logic [OW-1:0] NEG_LIM = OW'(32768);

	// front end: accelerometer magnitudes and norm squared
	ctl_t             ctl_s1, ctl_s2;
	logic [A_W-1:0]   amag_c [3];
	logic [SQ_W-1:0]  sq_s1 [3];
	logic [SB1-1:0]   sb_s1, sb_s2;
	logic [SQ_W-1:0]  n2_c;
	logic [SQ_W-1:0]  n2_s2;

	ctl_t             ctl_a, ctl_b, ctl_c, ctl_d, ctl_e, ctl_f;
	logic [ROOT_W-1:0] ra, rg;
	logic [SB1-1:0]   sb_a;
	logic [NW-1:0]    num1 [3];
	logic [QW-1:0]    quo1 [3];
	logic [SB2-1:0]   sb_b;
	logic signed [Q_W-1:0] quat_b [4];
	logic signed [G_W-1:0] g_c [4];
	logic [RAD_W-1:0] rad_d;
	logic [M_W-1:0]   m_d [4];
	logic [3:0]       neg_d;
	logic [SB3-1:0]   sb_e;
	logic [NW-1:0]    num2 [4];
	logic [QW-1:0]    quo2 [4];
	logic [3:0]       neg_f;

	logic [O_W-1:0]   sat_c [4];
	logic [O_W-1:0]   grad_q [4];
	logic             az_q, done_q;

	assign busy = 1'b0;

	assign amag_c[0] = accel_x[A_W-1] ? A_W'(-accel_x) : A_W'(accel_x);
	assign amag_c[1] = accel_y[A_W-1] ? A_W'(-accel_y) : A_W'(accel_y);
	assign amag_c[2] = accel_z[A_W-1] ? A_W'(-accel_z) : A_W'(accel_z);
	assign n2_c      = sq_s1[0] + sq_s1[1] + sq_s1[2];

	// advance front-end control, flag a zero accelerometer vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1     <= '{vld: start, az: 1'b0, gz: 1'b0};
			ctl_s2     <= '{vld: ctl_s1.vld, az: ~|n2_c, gz: ctl_s1.gz};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s1[i] <= SQ_W'(amag_c[i]) * SQ_W'(amag_c[i]);
		end
		sb_s1 <= {quat_w, quat_x, quat_y, quat_z, amag_c[0], amag_c[1], amag_c[2],
			accel_x[A_W-1], accel_y[A_W-1], accel_z[A_W-1]};
		sb_s2 <= sb_s1;
		n2_s2 <= n2_c;
	end

	// accelerometer norm
	ogs_sqrt #(.SBW(SB1)) u_sqrt_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_i  (ctl_s2),
		.rad_i  (RAD_W'(n2_s2) << (RAD_W - SQ_W)),
		.sb_i   (sb_s2),
		.ctl_o  (ctl_a),
		.root_o (ra),
		.sb_o   (sb_a)
	);

	// unit accelerometer vector, rounded
	for (genvar i = 0; i < 3; i++) begin : g_num1
		assign num1[i] = (NW'(sb_a[3 + (2 - i) * A_W +: A_W]) << (FRAC_BITS + 15))
			+ NW'(ra >> 1);
	end

	ogs_div #(.LN(3), .QW(QW), .SBW(SB2)) u_div_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_i  (ctl_a),
		.num_i  (num1),
		.den_i  (ra),
		.sb_i   ({sb_a[SB1-1 -: QV], sb_a[2:0]}),
		.ctl_o  (ctl_b),
		.quo_o  (quo1),
		.sb_o   (sb_b)
	);

	for (genvar i = 0; i < 4; i++) begin : g_quat
		assign quat_b[i] = $signed(sb_b[SB2 - 1 - i * Q_W -: Q_W]);
	end

	ogs_grad #(.FRAC_BITS(FRAC_BITS)) u_grad (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_i  (ctl_b),
		.quat_i (quat_b),
		.amag_i (quo1),
		.aneg_i ({sb_b[0], sb_b[1], sb_b[2]}),
		.ctl_o  (ctl_c),
		.g_o    (g_c)
	);

	ogs_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_i  (ctl_c),
		.g_i    (g_c),
		.ctl_o  (ctl_d),
		.rad_o  (rad_d),
		.m_o    (m_d),
		.neg_o  (neg_d)
	);

	// gradient norm
	ogs_sqrt #(.SBW(SB3)) u_sqrt_grad (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_i  (ctl_d),
		.rad_i  (rad_d),
		.sb_i   ({m_d[0], m_d[1], m_d[2], m_d[3], neg_d}),
		.ctl_o  (ctl_e),
		.root_o (rg),
		.sb_o   (sb_e)
	);

	// unit gradient, rounded
	for (genvar i = 0; i < 4; i++) begin : g_num2
		assign num2[i] = (NW'(sb_e[SB3 - 1 - i * M_W -: M_W]) << FRAC_BITS) + NW'(rg >> 1);
	end

	ogs_div #(.LN(4), .QW(QW), .SBW(4)) u_div_grad (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_i  (ctl_e),
		.num_i  (num2),
		.den_i  (rg),
		.sb_i   (sb_e[3:0]),
		.ctl_o  (ctl_f),
		.quo_o  (quo2),
		.sb_o   (neg_f)
	);

	// apply sign, saturate, drop to zero for the degenerate cases
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (ctl_f.az || ctl_f.gz) begin
				sat_c[i] = '0;
			end else if (neg_f[i]) begin
				sat_c[i] = (OW'(quo2[i]) > NEG_LIM) ? O_W'(NEG_LIM) : O_W'(-OW'(quo2[i]));
			end else begin
				sat_c[i] = (OW'(quo2[i]) > POS_LIM) ? O_W'(POS_LIM) : O_W'(quo2[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_f.vld;
		end
	end

	always_ff @(posedge clk) begin
		grad_q <= sat_c;
		az_q   <= ctl_f.az;
	end

	assign done       = done_q;
	assign grad_w     = $signed(grad_q[0]);
	assign grad_x     = $signed(grad_q[1]);
	assign grad_y     = $signed(grad_q[2]);
	assign grad_z     = $signed(grad_q[3]);
	assign accel_zero = az_q;

	// every request yields its result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("request did not produce a result on time");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching request");

	a_zero_accel: assert property (@(posedge clk) disable iff (!arst_n)
		done && accel_zero |-> grad_w == 0 && grad_x == 0 && grad_y == 0 && grad_z == 0)
		else $error("nonzero gradient with zero accelerometer vector");

endmodule

// File: design/ogs_sqrt.sv
// Pipelined integer square root, one result bit per stage
module ogs_sqrt #(
	parameter int SBW = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ogs_pkg::ctl_t               ctl_i,
	input  logic [ogs_pkg::RAD_W-1:0]   rad_i,
	input  logic [SBW-1:0]              sb_i,
	output ogs_pkg::ctl_t               ctl_o,
	output logic [ogs_pkg::ROOT_W-1:0]  root_o,
	output logic [SBW-1:0]              sb_o
);
	import ogs_pkg::*;

	localparam int NS  = ROOT_W;
	localparam int RMW = ROOT_W + 2;

	ctl_t               ctl_s  [NS];
	logic [ROOT_W-1:0]  root_s [NS];
	logic [SBW-1:0]     sb_s   [NS];
	logic [RAD_W-1:0]   x_s    [NS-1];
	logic [RMW-1:0]     rem_s  [NS-1];

	for (genvar k = 0; k < NS; k++) begin : g_st
		ctl_t              c_in;
		logic [RAD_W-1:0]  x_in;
		logic [RMW-1:0]    r_in;
		logic [ROOT_W-1:0] q_in;
		logic [SBW-1:0]    b_in;
		logic [RMW-1:0]    cur;
		logic [RMW-1:0]    trial;
		logic [RMW-1:0]    nrem;
		logic              ge;

		if (k == 0) begin : g_first
			assign c_in = ctl_i;
			assign x_in = rad_i;
			assign r_in = '0;
			assign q_in = '0;
			assign b_in = sb_i;
		end else begin : g_next
			assign c_in = ctl_s[k-1];
			assign x_in = x_s[k-1];
			assign r_in = rem_s[k-1];
			assign q_in = root_s[k-1];
			assign b_in = sb_s[k-1];
		end

		// bring down two radicand bits and try the next root bit
		assign cur   = {r_in[RMW-3:0], x_in[RAD_W-1 -: 2]};
		assign trial = {q_in, 2'b01};
		assign ge    = (cur >= trial);
		assign nrem  = ge ? (cur - trial) : cur;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else begin
				ctl_s[k] <= c_in;
			end
		end

		always_ff @(posedge clk) begin
			root_s[k] <= {q_in[ROOT_W-2:0], ge};
			sb_s[k]   <= b_in;
		end

		if (k < NS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k] <= nrem;
				x_s[k]   <= x_in << 2;
			end
		end
	end

	assign ctl_o  = ctl_s[NS-1];
	assign root_o = root_s[NS-1];
	assign sb_o   = sb_s[NS-1];

endmodule

// File: design/ogs_div.sv
// Pipelined restoring divider, several lanes over one shared divisor
module ogs_div #(
	parameter int LN  = 1,
	parameter int QW  = 16,
	parameter int SBW = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ogs_pkg::ctl_t                      ctl_i,
	input  logic [QW+ogs_pkg::ROOT_W-1:0]      num_i [LN],
	input  logic [ogs_pkg::ROOT_W-1:0]         den_i,
	input  logic [SBW-1:0]                     sb_i,
	output ogs_pkg::ctl_t                      ctl_o,
	output logic [QW-1:0]                      quo_o [LN],
	output logic [SBW-1:0]                     sb_o
);
	import ogs_pkg::*;

	localparam int DW = ROOT_W;
	localparam int NW = QW + DW;

	ctl_t           ctl_s [QW];
	logic [SBW-1:0] sb_s  [QW];
	logic [QW-1:0]  nq_s  [QW][LN];
	logic [DW-1:0]  den_s [QW-1];
	logic [DW-1:0]  r_s   [QW-1][LN];

	for (genvar k = 0; k < QW; k++) begin : g_st
		ctl_t           c_in;
		logic [SBW-1:0] b_in;
		logic [DW-1:0]  d_in;

		if (k == 0) begin : g_first
			assign c_in = ctl_i;
			assign b_in = sb_i;
			assign d_in = den_i;
		end else begin : g_next
			assign c_in = ctl_s[k-1];
			assign b_in = sb_s[k-1];
			assign d_in = den_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else begin
				ctl_s[k] <= c_in;
			end
		end

		always_ff @(posedge clk) begin
			sb_s[k] <= b_in;
		end

		if (k < QW - 1) begin : g_den
			always_ff @(posedge clk) begin
				den_s[k] <= d_in;
			end
		end

		for (genvar l = 0; l < LN; l++) begin : g_ln
			logic [DW-1:0] r_in;
			logic [QW-1:0] q_in;
			logic [DW:0]   t;
			logic [DW:0]   diff;
			logic          ge;

			if (k == 0) begin : g_first
				assign r_in = num_i[l][NW-1:QW];
				assign q_in = num_i[l][QW-1:0];
			end else begin : g_next
				assign r_in = r_s[k-1][l];
				assign q_in = nq_s[k-1][l];
			end

			// shift in the next dividend bit, subtract where it fits
			assign t    = {r_in, q_in[QW-1]};
			assign diff = t - {1'b0, d_in};
			assign ge   = (t >= {1'b0, d_in});

			always_ff @(posedge clk) begin
				nq_s[k][l] <= {q_in[QW-2:0], ge};
			end

			if (k < QW - 1) begin : g_rem
				always_ff @(posedge clk) begin
					r_s[k][l] <= ge ? diff[DW-1:0] : t[DW-1:0];
				end
			end
		end
	end

	assign ctl_o = ctl_s[QW-1];
	assign sb_o  = sb_s[QW-1];
	for (genvar l = 0; l < LN; l++) begin : g_out
		assign quo_o[l] = nq_s[QW-1][l];
	end

endmodule

// File: design/ogs_grad.sv
// Gravity error terms and objective gradient, five pipeline stages
module ogs_grad #(
	parameter int FRAC_BITS = ogs_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ogs_pkg::ctl_t                   ctl_i,
	input  logic signed [ogs_pkg::Q_W-1:0]  quat_i [4],
	input  logic [FRAC_BITS+1:0]            amag_i [3],
	input  logic [2:0]                      aneg_i,
	output ogs_pkg::ctl_t                   ctl_o,
	output logic signed [ogs_pkg::G_W-1:0]  g_o [4]
);
	import ogs_pkg::*;

	localparam int PW = 2 * Q_W;
	localparam int TW = PW + 2;
	localparam int XW = Q_W + F_W;

	// round to nearest by magnitude, halves away from zero
	function automatic logic signed [TW-1:0] rsr(input logic signed [TW-1:0] v);
		logic [TW-1:0] m;
		m = v[TW-1] ? TW'(-v) : TW'(v);
		m = (m + (TW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return v[TW-1] ? -$signed(m) : $signed(m);
	endfunction

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic signed [Q_W-1:0] q_s1 [4];
	logic signed [Q_W-1:0] q_s2 [4];
	logic signed [Q_W-1:0] q_s3 [4];
	logic signed [F_W-1:0] a_s1 [3];
	logic signed [F_W-1:0] a_s2 [3];
	logic signed [PW-1:0]  p_s1 [6];
	logic signed [TW-1:0]  t_s2 [3];
	logic signed [F_W-1:0] f_s3 [3];
	logic signed [XW-1:0]  m_s4 [10];
	logic signed [G_W-1:0] g_s5 [4];

	// advance control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// stage 1: quaternion products, signed unit accel
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			q_s1[i] <= quat_i[i];
		end
		for (int i = 0; i < 3; i++) begin
			a_s1[i] <= aneg_i[i] ? -$signed(F_W'(amag_i[i])) : $signed(F_W'(amag_i[i]));
		end
		p_s1[0] <= quat_i[1] * quat_i[3];
		p_s1[1] <= quat_i[0] * quat_i[2];
		p_s1[2] <= quat_i[0] * quat_i[1];
		p_s1[3] <= quat_i[2] * quat_i[3];
		p_s1[4] <= quat_i[1] * quat_i[1];
		p_s1[5] <= quat_i[2] * quat_i[2];
	end

	// stage 2: doubled product sums
	always_ff @(posedge clk) begin
		q_s2    <= q_s1;
		a_s2    <= a_s1;
		t_s2[0] <= (TW'(p_s1[0]) - TW'(p_s1[1])) <<< 1;
		t_s2[1] <= (TW'(p_s1[2]) + TW'(p_s1[3])) <<< 1;
		t_s2[2] <= (TW'(p_s1[4]) + TW'(p_s1[5])) <<< 1;
	end

	// stage 3: round back to Q format and form the error terms
	always_ff @(posedge clk) begin
		q_s3    <= q_s2;
		f_s3[0] <= F_W'(rsr(t_s2[0])) - a_s2[0];
		f_s3[1] <= F_W'(rsr(t_s2[1])) - a_s2[1];
		f_s3[2] <= $signed(F_W'(1) << FRAC_BITS) - F_W'(rsr(t_s2[2])) - a_s2[2];
	end

	// stage 4: quaternion times error products
	always_ff @(posedge clk) begin
		m_s4[0] <= q_s3[2] * f_s3[0];
		m_s4[1] <= q_s3[1] * f_s3[1];
		m_s4[2] <= q_s3[3] * f_s3[0];
		m_s4[3] <= q_s3[0] * f_s3[1];
		m_s4[4] <= q_s3[1] * f_s3[2];
		m_s4[5] <= q_s3[0] * f_s3[0];
		m_s4[6] <= q_s3[3] * f_s3[1];
		m_s4[7] <= q_s3[2] * f_s3[2];
		m_s4[8] <= q_s3[1] * f_s3[0];
		m_s4[9] <= q_s3[2] * f_s3[1];
	end

	// stage 5: gradient components
	always_ff @(posedge clk) begin
		g_s5[0] <= (G_W'(m_s4[1]) - G_W'(m_s4[0])) <<< 1;
		g_s5[1] <= ((G_W'(m_s4[2]) + G_W'(m_s4[3])) <<< 1) - (G_W'(m_s4[4]) <<< 2);
		g_s5[2] <= ((G_W'(m_s4[6]) - G_W'(m_s4[5])) <<< 1) - (G_W'(m_s4[7]) <<< 2);
		g_s5[3] <= (G_W'(m_s4[8]) + G_W'(m_s4[9])) <<< 1;
	end

	assign ctl_o = ctl_s5;
	assign g_o   = g_s5;

endmodule

// File: design/ogs_norm.sv
// Gradient magnitude range alignment and sum of squares, seven pipeline stages
module ogs_norm (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ogs_pkg::ctl_t                   ctl_i,
	input  logic signed [ogs_pkg::G_W-1:0]  g_i [4],
	output ogs_pkg::ctl_t                   ctl_o,
	output logic [ogs_pkg::RAD_W-1:0]       rad_o,
	output logic [ogs_pkg::M_W-1:0]         m_o [4],
	output logic [3:0]                      neg_o
);
	import ogs_pkg::*;

	localparam int NG  = G_W / 8;
	localparam int PSW = $clog2(G_W);
	localparam int SQW = 2 * M_W;

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic [G_W-1:0]   mg_s1 [4];
	logic [G_W-1:0]   mg_s2 [4];
	logic [G_W-1:0]   mg_s3 [4];
	logic [3:0]       neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic [G_W-1:0]   or_s1;
	logic [NG-1:0]    gnz_s2;
	logic [2:0]       gpos_s2 [NG];
	logic [PSW-1:0]   pos_s3;
	logic [M_W-1:0]   sh_s4 [4];
	logic [M_W-1:0]   sh_s5 [4];
	logic [M_W-1:0]   sh_s6 [4];
	logic [M_W-1:0]   sh_s7 [4];
	logic [SQW-1:0]   sq_s5 [4];
	logic [SQW:0]     ps_s6 [2];
	logic [RAD_W-1:0] rad_s7;

	logic [G_W-1:0]   mg_c [4];
	logic [NG-1:0]    gnz_c;
	logic [2:0]       gpos_c [NG];
	logic [PSW-1:0]   pos_c;
	logic [M_W-1:0]   sh_c [4];

	// advance control, flag a zero gradient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else begin
			ctl_s1    <= ctl_i;
			ctl_s2    <= '{vld: ctl_s1.vld, az: ctl_s1.az, gz: ~|or_s1};
			ctl_s3    <= ctl_s2;
			ctl_s4    <= ctl_s3;
			ctl_s5    <= ctl_s4;
			ctl_s6    <= ctl_s5;
			ctl_s7    <= ctl_s6;
		end
	end

	// stage 1: magnitudes and their OR, whose top bit is that of the largest
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mg_c[i] = g_i[i][G_W-1] ? G_W'(-g_i[i]) : G_W'(g_i[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			mg_s1[i]  <= mg_c[i];
			neg_s1[i] <= g_i[i][G_W-1];
		end
		or_s1 <= mg_c[0] | mg_c[1] | mg_c[2] | mg_c[3];
	end

	// stage 2: leading one within each byte
	always_comb begin
		for (int j = 0; j < NG; j++) begin
			gnz_c[j]  = |or_s1[8*j +: 8];
			gpos_c[j] = '0;
			for (int b = 0; b < 8; b++) begin
				if (or_s1[8*j+b]) gpos_c[j] = 3'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		mg_s2   <= mg_s1;
		neg_s2  <= neg_s1;
		gnz_s2  <= gnz_c;
		gpos_s2 <= gpos_c;
	end

	// stage 3: pick the top nonzero byte
	always_comb begin
		pos_c = '0;
		for (int j = 0; j < NG; j++) begin
			if (gnz_s2[j]) pos_c = PSW'(j * 8) | PSW'(gpos_s2[j]);
		end
	end

	always_ff @(posedge clk) begin
		mg_s3  <= mg_s2;
		neg_s3 <= neg_s2;
		pos_s3 <= pos_c;
	end

	// stage 4: shift all by one amount so the largest sits just below bit 30
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (pos_s3 >= PSW'(M_W - 1)) begin
				sh_c[i] = M_W'(mg_s3[i] >> (pos_s3 - PSW'(M_W - 1)));
			end else begin
				sh_c[i] = M_W'(mg_s3[i] << (PSW'(M_W - 1) - pos_s3));
			end
		end
	end

	always_ff @(posedge clk) begin
		sh_s4  <= sh_c;
		neg_s4 <= neg_s3;
	end

	// stage 5: squares
	always_ff @(posedge clk) begin
		sh_s5  <= sh_s4;
		neg_s5 <= neg_s4;
		for (int i = 0; i < 4; i++) begin
			sq_s5[i] <= SQW'(sh_s4[i]) * SQW'(sh_s4[i]);
		end
	end

	// stage 6 and 7: adder tree
	always_ff @(posedge clk) begin
		sh_s6    <= sh_s5;
		neg_s6   <= neg_s5;
		ps_s6[0] <= (SQW + 1)'(sq_s5[0]) + (SQW + 1)'(sq_s5[1]);
		ps_s6[1] <= (SQW + 1)'(sq_s5[2]) + (SQW + 1)'(sq_s5[3]);
		sh_s7    <= sh_s6;
		neg_s7   <= neg_s6;
		rad_s7   <= RAD_W'(ps_s6[0]) + RAD_W'(ps_s6[1]);
	end

	assign ctl_o = ctl_s7;
	assign rad_o = rad_s7;
	assign m_o   = sh_s7;
	assign neg_o = neg_s7;

endmodule

// File: verif/tb.sv
// Testbench for the orientation gradient step: directed table plus random requests
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = ogs_pkg::FRAC_BITS_DEF;
	localparam int LATENCY = 81 + 2 * FB;
	localparam int WATCHDOG = 4000;
	localparam int N_RANDOM = 1630;

	typedef struct {
		logic signed [15:0] qw, qx, qy, qz, ax, ay, az;
	} imu_req_t;

	typedef struct {
		logic signed [15:0] gw, gx, gy, gz;
		logic azero;
		logic typed;  // expectation typed into the table rather than predicted
	} grad_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, accel_zero;
	logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
	logic signed [15:0] grad_w, grad_x, grad_y, grad_z;

	grad_res_t pending_grads[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit timed_out = 1'b0;

	orientation_gradient_step dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.done(done), .grad_w(grad_w), .grad_x(grad_x), .grad_y(grad_y),
		.grad_z(grad_z), .accel_zero(accel_zero)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned abs64(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint round_shift(longint v, int n);
		longint unsigned m;
		m = (abs64(v) + (64'd1 << (n - 1))) >> n;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint round_div(longint unsigned m, bit neg, longint unsigned d);
		longint unsigned q;
		q = (m + d / 2) / d;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	// Compute the unit gradient for one request
	function automatic grad_res_t predict_gradient(imu_req_t r);
		grad_res_t res;
		longint w, x, y, z, fx, fy, fz;
		longint a[3], an[3], g[4];
		longint unsigned m[4], n2, ra, rg, big;
		w = r.qw; x = r.qx; y = r.qy; z = r.qz;
		a[0] = r.ax; a[1] = r.ay; a[2] = r.az;
		res = '{default: '0};
		n2 = abs64(a[0]) ** 2 + abs64(a[1]) ** 2 + abs64(a[2]) ** 2;
		if (n2 == 0) begin
			res.azero = 1'b1;
			return res;
		end
		ra = int_sqrt(n2 << 30);
		for (int i = 0; i < 3; i++)
			an[i] = round_div(abs64(a[i]) << (FB + 15), a[i] < 0, ra);
		fx = round_shift(2 * (x * z - w * y), FB) - an[0];
		fy = round_shift(2 * (w * x + y * z), FB) - an[1];
		fz = (longint'(1) << FB) - round_shift(2 * (x * x + y * y), FB) - an[2];
		g[0] = -2 * y * fx + 2 * x * fy;
		g[1] = 2 * z * fx + 2 * w * fy - 4 * x * fz;
		g[2] = -2 * w * fx + 2 * z * fy - 4 * y * fz;
		g[3] = 2 * x * fx + 2 * y * fy;
		big = 0;
		for (int i = 0; i < 4; i++) begin
			m[i] = abs64(g[i]);
			if (m[i] > big) big = m[i];
		end
		if (big == 0) return res;
		// bring the largest magnitude into [2^29, 2^30)
		while (big >= (64'd1 << 30)) begin
			big >>= 1;
			for (int i = 0; i < 4; i++) m[i] >>= 1;
		end
		while (big < (64'd1 << 29)) begin
			big <<= 1;
			for (int i = 0; i < 4; i++) m[i] <<= 1;
		end
		rg = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2] + m[3] * m[3]);
		res.gw = clamp16(round_div(m[0] << FB, g[0] < 0, rg));
		res.gx = clamp16(round_div(m[1] << FB, g[1] < 0, rg));
		res.gy = clamp16(round_div(m[2] << FB, g[2] < 0, rg));
		res.gz = clamp16(round_div(m[3] << FB, g[3] < 0, rg));
		return res;
	endfunction

	function automatic logic signed [15:0] rand_field();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return $urandom_range(0, 1) ? 16'sh4000 : 16'shc000;
			3: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly near-unit quaternions with plausible gravity, rest drawn from corner and random field values
	function automatic imu_req_t rand_request();
		imu_req_t r;
		if ($urandom_range(0, 3) != 0) begin
			r.qw = 16'sd16384 - 16'($urandom_range(0, 4000));
			r.qx = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
			r.qy = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
			r.qz = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
			r.ax = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
			r.ay = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
			r.az = 16'($urandom_range(8000, 20000));
			if ($urandom_range(0, 1)) r.az = -r.az;
		end else begin
			r.qw = rand_field(); r.qx = rand_field(); r.qy = rand_field();
			r.qz = rand_field();
			r.ax = rand_field(); r.ay = rand_field(); r.az = rand_field();
			if ($urandom_range(0, 30) == 0) {r.ax, r.ay, r.az} = '0;
		end
		return r;
	endfunction

	// Hold the request until it is taken, after a random gap
	task automatic send_request(imu_req_t r);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		quat_w <= r.qw; quat_x <= r.qx; quat_y <= r.qy; quat_z <= r.qz;
		accel_x <= r.ax; accel_y <= r.ay; accel_z <= r.az;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		grad_res_t want;
		if (arst_n && done) begin
			if (pending_grads.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
			end else begin
				want = pending_grads.pop_front();
				if (grad_w !== want.gw || grad_x !== want.gx || grad_y !== want.gy ||
					grad_z !== want.gz || accel_zero !== want.azero) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d %0d %0d %0d z%0b got %0d %0d %0d %0d z%0b",
							want.gw, want.gx, want.gy, want.gz, want.azero,
							grad_w, grad_x, grad_y, grad_z, accel_zero);
				end
			end
		end
	end

	// Count cycles with no request or result taken
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			timed_out = 1'b1;
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		imu_req_t dir_reqs[$];
		grad_res_t dir_exp[$];
		imu_req_t r;
		grad_res_t e, p;

		// directed table: typed results only where obvious
		dir_reqs = '{
			'{16'sd16384, 0, 0, 0, 0, 0, 0},
			'{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 0, 0, 0},
			'{16'sd16384, 0, 0, 0, 0, 0, 16'sd100},
			'{16'sd16384, 0, 0, 0, 0, 0, 16'sh7fff},
			'{0, 0, 0, 0, 0, 0, 16'sh8000},
			'{16'sd16384, 0, 0, 0, 16'sh7fff, 0, 0},
			'{16'sd16384, 0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000},
			'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
			'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
			'{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff},
			'{0, 16'sd16384, 0, 0, 16'sd1, 16'sd1, 16'sd1},
			'{0, 0, 16'sd16384, 0, 16'sh8000, 16'sh7fff, 0},
			'{0, 0, 0, 16'sd16384, 0, 0, 16'sh8000},
			'{16'sd11585, 16'sd11585, 0, 0, 0, 16'sd1000, 16'sd1000},
			'{16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1},
			'{16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 0, 0},
			'{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 16'shaaaa}
		};
		dir_exp = '{
			'{0, 0, 0, 0, 1'b1, 1'b1},  // zero accelerometer
			'{0, 0, 0, 0, 1'b1, 1'b1},
			'{0, 0, 0, 0, 1'b0, 1'b1},  // level and at rest: zero gradient
			'{0, 0, 0, 0, 1'b0, 1'b1},
			'{0, 0, 0, 0, 1'b0, 1'b1}   // zero quaternion: zero gradient
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_reqs[i]) begin
			p = predict_gradient(dir_reqs[i]);
			if (i < dir_exp.size()) begin
				e = dir_exp[i];
			end else begin
				e = p;
			end
			pending_grads.push_back(e);
			send_request(dir_reqs[i]);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			// requests 201 to 499 go back to back; drain the pipeline once mid-run
			if (n == N_RANDOM / 2) begin
				start <= 1'b0;
				while (pending_grads.size() != 0) @(negedge clk);
			end
			r = rand_request();
			if (n > 200 && n < 500) begin
				quat_w <= r.qw; quat_x <= r.qx; quat_y <= r.qy; quat_z <= r.qz;
				accel_x <= r.ax; accel_y <= r.ay; accel_z <= r.az;
				start <= 1'b1;
				pending_grads.push_back(predict_gradient(r));
				@(posedge clk);
				while (busy) @(posedge clk);
				@(negedge clk);
			end else begin
				pending_grads.push_back(predict_gradient(r));
				send_request(r);
			end
		end
		start <= 1'b0;

		while (pending_grads.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);

		if (mismatches == 0 && !timed_out) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// File: sim.f
design/ogs_pkg.sv
design/ogs_sqrt.sv
design/ogs_div.sv
design/ogs_grad.sv
design/ogs_norm.sv
design/orientation_gradient_step.sv
verif/tb.sv
